>>> hw/rtl/qptrk_pkg.sv
package qptrk_pkg;

  localparam int CountW  = 16;
  localparam int TimeW   = 32;
  localparam int TotalW  = 32;
  localparam int DivW    = 9;
  localparam int DbW     = 10;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 10;
  localparam int DirW    = 2;
  localparam int BtnW    = 2;
  localparam int StepCntW = $clog2(TotalW);

  localparam logic [CfgIdxW-1:0] CFG_STEP_DIVISOR  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INVERT_DIR    = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_EN     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_BUTTON_HIGH   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_MS   = 3'd4;

  localparam logic [DivW-1:0] STEP_DIV_RESET = 9'd2;
  localparam logic [DbW-1:0]  DEBOUNCE_RESET = 10'd20;

  localparam logic REQ_POLL = 1'b0;
  localparam logic REQ_EDGE = 1'b1;

  localparam logic [DirW-1:0] DIR_NONE = 2'd0;
  localparam logic [DirW-1:0] DIR_CW   = 2'd1;
  localparam logic [DirW-1:0] DIR_CCW  = 2'd2;

  localparam logic [BtnW-1:0] BSTATE_UP    = 2'd0;
  localparam logic [BtnW-1:0] BSTATE_DOWN  = 2'd1;
  localparam logic [BtnW-1:0] BSTATE_CLICK = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_SETUP,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic latch_in;
    logic update;
    logic setup;
    logic div_step;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic is_edge;
    logic bypass;
    logic div_last;
  } dp_status_t;

endpackage

>>> hw/rtl/qptrk_ctrl.sv
module qptrk_ctrl
  import qptrk_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = status.is_edge ? ST_IDLE : ST_SETUP;
      ST_SETUP: state_nxt = status.bypass ? ST_FIN : ST_DIV;
      ST_DIV:   if (status.div_last) state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.latch_in = in_valid;
      end
      ST_UPD:   cmd.update = 1'b1;
      ST_SETUP: cmd.setup = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.load_out = out_free;
      default:  in_stall = 1'b1;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hw/rtl/qptrk_dp.sv
module qptrk_dp
  import qptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_req_type,
  input  logic [CountW-1:0]   in_counter_now,
  input  logic [TimeW-1:0]    in_time_ms,
  input  logic                in_button_level,
  output logic [TotalW-1:0]   out_position,
  output logic [DirW-1:0]     out_direction,
  output logic [BtnW-1:0]     out_button_state,
  input  dp_cmd_t             cmd,
  output dp_status_t          status
);

  logic [DivW-1:0] step_div_r;
  logic            invert_r;
  logic            btn_en_r;
  logic            btn_high_r;
  logic [DbW-1:0]  debounce_r;

  logic              req_r;
  logic [CountW-1:0] counter_r;
  logic [TimeW-1:0]  time_r;
  logic              level_r;

  logic [CountW-1:0] last_counter_r, last_counter_nxt;
  logic [TotalW-1:0] total_r, total_nxt;
  logic              win_open_r, win_open_nxt;
  logic [TimeW-1:0]  win_end_r, win_end_nxt;
  logic              stable_r, stable_nxt;
  logic [DirW-1:0]   dir_r, dir_nxt;
  logic [BtnW-1:0]   btn_r, btn_nxt;

  logic                neg_r;
  logic [TotalW-1:0]   quo_r, quo_nxt;
  logic [DivW-1:0]     rem_r, rem_nxt;
  logic [StepCntW-1:0] step_r;

  logic [TotalW-1:0] pos_r;
  logic [DirW-1:0]   odir_r;
  logic [BtnW-1:0]   obtn_r;

  logic [CountW-1:0] delta_raw, delta_adj;
  logic [DirW-1:0]   dir_raw;
  logic [TimeW-1:0]  since_end;
  logic              expired, pressed;
  logic [DivW:0]     shifted, diff;
  logic              ge;
  logic [TotalW-1:0] result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_div_r <= STEP_DIV_RESET;
      invert_r   <= 1'b0;
      btn_en_r   <= 1'b1;
      btn_high_r <= 1'b0;
      debounce_r <= DEBOUNCE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STEP_DIVISOR: step_div_r <= cfg_data[DivW-1:0];
        CFG_INVERT_DIR:   invert_r   <= cfg_data[0];
        CFG_BUTTON_EN:    btn_en_r   <= cfg_data[0];
        CFG_BUTTON_HIGH:  btn_high_r <= cfg_data[0];
        CFG_DEBOUNCE_MS:  debounce_r <= cfg_data[DbW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      req_r     <= in_req_type;
      counter_r <= in_counter_now;
      time_r    <= in_time_ms;
      level_r   <= in_button_level;
    end
  end

  always_comb begin
    delta_raw = counter_r - last_counter_r;
    priority if (delta_raw == '0) begin
      dir_raw = DIR_NONE;
    end else if (delta_raw[CountW-1]) begin
      dir_raw = DIR_CCW;
    end else begin
      dir_raw = DIR_CW;
    end
    delta_adj = invert_r ? (CountW'(0) - delta_raw) : delta_raw;
    since_end = time_r - win_end_r;
    expired   = win_open_r && !since_end[TimeW-1];
    pressed   = btn_high_r ? level_r : !level_r;
  end

  always_comb begin
    last_counter_nxt = last_counter_r;
    total_nxt        = total_r;
    win_open_nxt     = win_open_r;
    win_end_nxt      = win_end_r;
    stable_nxt       = stable_r;
    dir_nxt          = dir_r;
    btn_nxt          = btn_r;
    if (cmd.update) begin
      if (req_r == REQ_EDGE) begin
        if (btn_en_r) begin
          win_open_nxt = 1'b1;
          win_end_nxt  = time_r + {{(TimeW-DbW){1'b0}}, debounce_r};
        end
      end else begin
        last_counter_nxt = counter_r;
        total_nxt = total_r + {{(TotalW-CountW){delta_adj[CountW-1]}}, delta_adj};
        if (invert_r && dir_raw == DIR_CW) begin
          dir_nxt = DIR_CCW;
        end else if (invert_r && dir_raw == DIR_CCW) begin
          dir_nxt = DIR_CW;
        end else begin
          dir_nxt = dir_raw;
        end
        btn_nxt = BSTATE_UP;
        if (btn_en_r) begin
          if (expired) begin
            win_open_nxt = 1'b0;
            stable_nxt   = pressed;
          end
          if (expired && stable_r && !pressed) begin
            btn_nxt = BSTATE_CLICK;
          end else if (expired ? pressed : stable_r) begin
            btn_nxt = BSTATE_DOWN;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_counter_r <= '0;
      total_r        <= '0;
      win_open_r     <= 1'b0;
      win_end_r      <= '0;
      stable_r       <= 1'b0;
    end else begin
      last_counter_r <= last_counter_nxt;
      total_r        <= total_nxt;
      win_open_r     <= win_open_nxt;
      win_end_r      <= win_end_nxt;
      stable_r       <= stable_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dir_r <= dir_nxt;
    btn_r <= btn_nxt;
  end

  always_comb begin
    shifted = {rem_r, quo_r[TotalW-1]};
    ge      = shifted >= {1'b0, step_div_r};
    diff    = shifted - {1'b0, step_div_r};
    rem_nxt = ge ? diff[DivW-1:0] : shifted[DivW-1:0];
    quo_nxt = {quo_r[TotalW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      neg_r  <= total_r[TotalW-1];
      quo_r  <= total_r[TotalW-1] ? (TotalW'(0) - total_r) : total_r;
      rem_r  <= '0;
      step_r <= '0;
    end else if (cmd.div_step) begin
      quo_r  <= quo_nxt;
      rem_r  <= rem_nxt;
      step_r <= step_r + StepCntW'(1);
    end
  end

  assign result = status.bypass ? total_r
                : (neg_r ? (TotalW'(0) - quo_r) : quo_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      pos_r  <= result;
      odir_r <= dir_r;
      obtn_r <= btn_r;
    end
  end

  assign status.is_edge  = (req_r == REQ_EDGE);
  assign status.bypass   = (step_div_r[DivW-1:1] == '0);
  assign status.div_last = (step_r == StepCntW'(TotalW - 1));

  assign out_position     = pos_r;
  assign out_direction    = odir_r;
  assign out_button_state = obtn_r;

endmodule

>>> hw/rtl/quadrature_position_and_button_tracker.sv
// Channel  | Handshake          | Beat
// ---------+--------------------+-------------------------------------------------
// in_      | in_valid/in_stall  | req_type, counter_now, time_ms, button_level
// out_     | out_valid/out_stall| position, direction, button_state
// cfg_     | cfg_valid/cfg_ready| cfg_index, cfg_data (cfg_ready is always high)
//
// A poll runs update, setup, 32 steps of the bit-serial restoring divider, then the
// output load. A divisor of 0 or 1 skips the divider. An edge beat gives no result.
// rst_n is synchronous; it restores the register defaults and clears the state.
// A new beat is taken while a result waits; a held out_stall holds the output
// register and stalls the load of the next poll's result.
module quadrature_position_and_button_tracker
  import qptrk_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [CountW-1:0]   in_counter_now,
  input  logic [TimeW-1:0]    in_time_ms,
  input  logic                in_button_level,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [TotalW-1:0]   out_position,
  output logic [DirW-1:0]     out_direction,
  output logic [BtnW-1:0]     out_button_state
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  qptrk_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  qptrk_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_counter_now   (in_counter_now),
    .in_time_ms       (in_time_ms),
    .in_button_level  (in_button_level),
    .out_position     (out_position),
    .out_direction    (out_direction),
    .out_button_state (out_button_state),
    .cmd              (cmd),
    .status           (status)
  );

endmodule

>>> hw/rtl/qptrk_chk.sv
module qptrk_chk
  import qptrk_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input logic [TotalW-1:0]   out_position,
  input logic [DirW-1:0]     out_direction,
  input logic [BtnW-1:0]     out_button_state
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_position) && $stable(out_direction)
      && $stable(out_button_state))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat taken before the first was processed");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result raised too soon after accept");

  a_dir_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_direction != 2'd3 && out_button_state != 2'd3)
    else $error("bad direction or button code on result");

endmodule

bind quadrature_position_and_button_tracker qptrk_chk u_qptrk_chk (.*);

>>> dv/quadrature_position_and_button_tracker_test.sv
module quadrature_position_and_button_tracker_test;
  import qptrk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic              req;
    logic [CountW-1:0] count;
    logic [TimeW-1:0]  tms;
    logic              level;
  } tracker_beat_t;

  typedef struct {
    logic [TotalW-1:0] position;
    logic [DirW-1:0]   direction;
    logic [BtnW-1:0]   button_state;
  } track_result_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                in_req_type = REQ_POLL;
  logic [CountW-1:0]   in_counter_now = '0;
  logic [TimeW-1:0]    in_time_ms = '0;
  logic                in_button_level = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [TotalW-1:0]   out_position;
  logic [DirW-1:0]     out_direction;
  logic [BtnW-1:0]     out_button_state;

  tracker_beat_t pending_beats[$];
  track_result_t due_results[$];
  int unsigned   mismatches = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   stall_pct = 0;
  logic          in_taken = 1'b0;
  logic          hold_go = 1'b0;
  logic          hold_on = 1'b0;

  // tracker image
  logic [DivW-1:0]   cur_div;
  logic              cur_invert;
  logic              cur_btn_en;
  logic              cur_act_high;
  logic [DbW-1:0]    cur_db_ms;
  logic [CountW-1:0] last_count;
  logic [TotalW-1:0] acc_total;
  logic              win_open;
  logic [TimeW-1:0]  win_end;
  logic              btn_stable;

  // stimulus timeline
  logic [CountW-1:0] tb_count = '0;
  logic [TimeW-1:0]  tb_now = '0;

  quadrature_position_and_button_tracker DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_req_type(in_req_type),
    .in_counter_now(in_counter_now),
    .in_time_ms(in_time_ms),
    .in_button_level(in_button_level),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_position(out_position),
    .out_direction(out_direction),
    .out_button_state(out_button_state)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void clear_tracker();
    cur_div = STEP_DIV_RESET;
    cur_invert = 1'b0;
    cur_btn_en = 1'b1;
    cur_act_high = 1'b0;
    cur_db_ms = DEBOUNCE_RESET;
    last_count = '0;
    acc_total = '0;
    win_open = 1'b0;
    win_end = '0;
    btn_stable = 1'b0;
  endfunction

  function automatic void apply_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    case (idx)
      CFG_STEP_DIVISOR: cur_div = d[DivW-1:0];
      CFG_INVERT_DIR:   cur_invert = d[0];
      CFG_BUTTON_EN:    cur_btn_en = d[0];
      CFG_BUTTON_HIGH:  cur_act_high = d[0];
      CFG_DEBOUNCE_MS:  cur_db_ms = d[DbW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void track_beat(tracker_beat_t b);
    logic [CountW-1:0] delta;
    logic [TimeW-1:0]  gap;
    logic [TotalW-1:0] mag;
    logic [TotalW-1:0] quo;
    logic              pressed;
    logic              clicked;
    track_result_t     r;
    if (b.req == REQ_EDGE) begin
      if (cur_btn_en) begin
        win_open = 1'b1;
        win_end = b.tms + TimeW'(cur_db_ms);
      end
      return;
    end
    delta = b.count - last_count;
    last_count = b.count;
    if (delta == '0) begin
      r.direction = DIR_NONE;
    end else if (delta[CountW-1]) begin
      r.direction = DIR_CCW;
    end else begin
      r.direction = DIR_CW;
    end
    if (cur_invert) begin
      if (r.direction == DIR_CW) begin
        r.direction = DIR_CCW;
      end else if (r.direction == DIR_CCW) begin
        r.direction = DIR_CW;
      end
      delta = -delta;
    end
    acc_total = acc_total + {{(TotalW-CountW){delta[CountW-1]}}, delta};
    r.button_state = BSTATE_UP;
    if (cur_btn_en) begin
      clicked = 1'b0;
      gap = b.tms - win_end;
      if (win_open && !gap[TimeW-1]) begin
        pressed = cur_act_high ? b.level : !b.level;
        win_open = 1'b0;
        clicked = btn_stable && !pressed;
        btn_stable = pressed;
      end
      if (clicked) begin
        r.button_state = BSTATE_CLICK;
      end else begin
        r.button_state = btn_stable ? BSTATE_DOWN : BSTATE_UP;
      end
    end
    if (cur_div <= 1) begin
      r.position = acc_total;
    end else begin
      mag = acc_total[TotalW-1] ? -acc_total : acc_total;
      quo = mag / TotalW'(cur_div);
      r.position = acc_total[TotalW-1] ? -quo : quo;
    end
    due_results.push_back(r);
  endfunction

  always @(negedge clk) begin : feed
    tracker_beat_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_beats.pop_front();
        in_valid <= 1'b1;
        in_req_type <= nxt.req;
        in_counter_now <= nxt.count;
        in_time_ms <= nxt.tms;
        in_button_level <= nxt.level;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_stall <= rst_n && (hold_on || ($urandom_range(99) < stall_pct));
  end

  // hold the result side off for a long stretch once
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_on = 1'b1;
    repeat (400) @(posedge clk);
    hold_on = 1'b0;
  end

  always @(posedge clk) begin : watch
    track_result_t want;
    tracker_beat_t seen;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected beat: expected none, got position %0d dir %0d btn %0d",
                   $time, $signed(out_position), out_direction, out_button_state);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          if (out_position !== want.position) begin
            $display("%0t position: expected %0d, got %0d",
                     $time, $signed(want.position), $signed(out_position));
            mismatches++;
          end
          if (out_direction !== want.direction) begin
            $display("%0t direction: expected %0d, got %0d",
                     $time, want.direction, out_direction);
            mismatches++;
          end
          if (out_button_state !== want.button_state) begin
            $display("%0t button_state: expected %0d, got %0d",
                     $time, want.button_state, out_button_state);
            mismatches++;
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        apply_cfg(cfg_index, cfg_data);
      end
      if (in_valid && !in_stall) begin
        seen.req = in_req_type;
        seen.count = in_counter_now;
        seen.tms = in_time_ms;
        seen.level = in_button_level;
        track_beat(seen);
      end
    end
    in_taken <= rst_n && in_valid && !in_stall;
  end

  task automatic queue_beat(logic req, logic [CountW-1:0] cnt, logic [TimeW-1:0] tms,
                            logic lvl);
    tracker_beat_t b;
    b.req = req;
    b.count = cnt;
    b.tms = tms;
    b.level = lvl;
    if (req == REQ_POLL) begin
      tb_count = cnt;
    end
    tb_now = tms;
    pending_beats.push_back(b);
  endtask

  task automatic queue_move(logic [CountW-1:0] delta, int unsigned dt, logic lvl);
    queue_beat(REQ_POLL, tb_count + delta, tb_now + dt, lvl);
  endtask

  function automatic logic [CountW-1:0] rand_delta();
    logic [CountW-1:0] d;
    d = CountW'($urandom_range(40));
    case ($urandom_range(3))
      0: return '0;
      1: return d;
      2: return -d;
      default: return CountW'($urandom);
    endcase
  endfunction

  task automatic queue_burst(int unsigned n);
    int unsigned    made;
    int unsigned    polls;
    logic           settle;
    logic [TimeW-1:0] edge_at;
    logic [TimeW-1:0] span;
    made = 0;
    while (made < n) begin
      case ($urandom_range(9))
        0: begin
          queue_beat(1'($urandom_range(1)), CountW'($urandom), $urandom,
                     1'($urandom_range(1)));
          made++;
        end
        1, 2, 3: begin
          queue_move(rand_delta(), $urandom_range(50), 1'($urandom_range(1)));
          made++;
        end
        default: begin
          settle = 1'($urandom_range(1));
          edge_at = tb_now;
          repeat ($urandom_range(1, 3)) begin
            edge_at = tb_now + $urandom_range(3);
            queue_beat(REQ_EDGE, CountW'($urandom), edge_at, 1'($urandom_range(1)));
            made++;
          end
          polls = $urandom_range(1, 6);
          for (int k = 1; k < polls; k++) begin
            queue_move(rand_delta(), $urandom_range(cur_db_ms / 2 + 2),
                       ($urandom_range(3) != 0) ? settle : !settle);
            made++;
          end
          span = tb_now - edge_at;
          if (span < TimeW'(cur_db_ms)) begin
            tb_now = edge_at + TimeW'(cur_db_ms);
          end
          queue_move(rand_delta(), $urandom_range(2), settle);
          made++;
        end
      endcase
    end
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(logic [DivW-1:0] div, logic inv, logic en, logic hi,
                          logic [DbW-1:0] db);
    logic [CfgDataW-1:0] pad;
    pad = CfgDataW'($urandom);
    write_reg(CFG_STEP_DIVISOR, {pad[CfgDataW-1:DivW], div});
    write_reg(CFG_INVERT_DIR, {pad[CfgDataW-1:1], inv});
    write_reg(CFG_BUTTON_EN, {~pad[CfgDataW-1:1], en});
    write_reg(CFG_BUTTON_HIGH, {pad[CfgDataW-1:1], hi});
    write_reg(CFG_DEBOUNCE_MS, db);
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (pending_beats.size() != 0 || in_valid || due_results.size() != 0);
    repeat (12) @(posedge clk);
  endtask

  task automatic set_pacing(int unsigned phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  stall_pct = 0;  end
      1: begin send_idle_pct = 49; stall_pct = 0;  end
      2: begin send_idle_pct = 0;  stall_pct = 49; end
      default: begin send_idle_pct = 33; stall_pct = 33; end
    endcase
  endtask

  initial begin
    clear_tracker();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    set_pacing(0);

    queue_beat(REQ_POLL, 16'h0000, 32'h0000_0000, 1'b1);
    queue_beat(REQ_POLL, 16'h7FFF, 32'h0000_0001, 1'b1);
    queue_beat(REQ_POLL, 16'hFFFF, 32'h0000_0002, 1'b0);
    queue_beat(REQ_POLL, 16'h0000, 32'h0000_0003, 1'b1);
    queue_beat(REQ_POLL, 16'h8000, 32'h0000_0003, 1'b1);
    queue_beat(REQ_EDGE, 16'hFFFF, 32'hFFFF_FFF0, 1'b0);
    queue_beat(REQ_POLL, 16'h8000, 32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_POLL, 16'h8001, 32'h0000_0004, 1'b0);
    queue_beat(REQ_EDGE, 16'h1234, 32'h0000_0064, 1'b1);
    queue_beat(REQ_EDGE, 16'h0000, 32'h0000_006E, 1'b0);
    queue_beat(REQ_POLL, 16'h8000, 32'h0000_007D, 1'b1);
    queue_beat(REQ_POLL, 16'h8000, 32'h0000_0082, 1'b1);
    queue_beat(REQ_POLL, 16'h7FFF, 32'h0000_0083, 1'b1);
    queue_beat(REQ_EDGE, 16'hAAAA, 32'h7FFF_FFFF, 1'b1);
    queue_beat(REQ_POLL, 16'h5555, 32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_POLL, 16'hFFFF, 32'h0000_0000, 1'b1);
    queue_beat(REQ_POLL, 16'h0000, 32'hFFFF_FFFF, 1'b0);
    queue_beat(REQ_EDGE, 16'h0000, 32'h8000_0000, 1'b1);
    queue_beat(REQ_POLL, 16'h0000, 32'h0000_0000, 1'b1);
    queue_beat(REQ_POLL, 16'h0001, 32'h8000_0014, 1'b1);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: set_regs(0, 1'b1, 1'b1, 1'b1, 0);
        1: set_regs(1, 1'b0, 1'b1, 1'b0, 1000);
        2: set_regs(256, 1'b1, 1'b0, 1'b0, 20);
        3: set_regs(3, 1'b0, 1'b1, 1'b1, 1023);
        4: set_regs(511, 1'b1, 1'b1, 1'b0, 5);
        5: set_regs(2, 1'b0, 1'b1, 1'b0, 20);
        default: set_regs(DivW'($urandom_range(1, 256)), 1'($urandom_range(1)),
                          1'($urandom_range(1)), 1'($urandom_range(1)),
                          DbW'($urandom_range(1000)));
      endcase
      if (p == 5) begin
        for (int k = CFG_DEBOUNCE_MS + 1; k < 2 ** CfgIdxW; k++) begin
          write_reg(CfgIdxW'(k), CfgDataW'($urandom));
        end
      end
      @(posedge clk);
      set_pacing(p);
      if (p == 4) begin
        hold_go = 1'b1;
      end
      queue_move(16'h8000, 1, 1'b0);
      queue_move(16'h7FFF, 1, 1'b1);
      queue_move(16'h0000, 0, 1'b0);
      queue_burst(148);
      queue_beat(REQ_EDGE, CountW'($urandom), tb_now + 1, 1'($urandom_range(1)));
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("[quadrature_position_and_button_tracker] OK");
    end else begin
      $display("[quadrature_position_and_button_tracker] ERROR");
    end
    $finish;
  end

  initial begin
    #(64'd30_000_000);
    $display("[quadrature_position_and_button_tracker] ERROR");
    $finish;
  end

endmodule
